// ===== hw/rtl/cfsd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfsd_pkg
// Shared types and constants for the compact field stream decoder.
// ----------------------------------------------------------------------------
package cfsd_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam int unsigned HDR_LAST_BIT   = 7;
    localparam int unsigned HDR_STRING_BIT = 6;
    localparam int unsigned HDR_SIGNED_BIT = 5;
    localparam int unsigned STR_LEN_W      = 6;
    localparam int unsigned INT_LEN_W      = 5;
    localparam int unsigned INT_LEN_MAX    = 4;

    typedef enum logic [2:0] {
        KIND_COUNT    = 3'd0,
        KIND_CHAR     = 3'd1,
        KIND_EMPTY    = 3'd2,
        KIND_SIGNED   = 3'd3,
        KIND_UNSIGNED = 3'd4,
        KIND_ERROR    = 3'd5
    } kind_t;

    // Back-end operation carried by each queued token.
    typedef enum logic [1:0] {
        OP_EMIT = 2'd0,
        OP_ACC  = 2'd1,
        OP_LAST = 2'd2
    } tok_op_t;

    typedef struct packed {
        tok_op_t    op;
        kind_t      kind;
        logic [7:0] data;
        logic       field_end;
        logic       struct_end;
        logic       stream_end;
        logic       is_signed;
        logic [2:0] int_len;
    } token_t;

endpackage

// ===== hw/rtl/cfsd_front.sv =====
// ----------------------------------------------------------------------------
// cfsd_front
// Byte parser: tracks stream phase, counts, lengths; emits one token per
// byte that produces a result or feeds the integer accumulator.
// ----------------------------------------------------------------------------
module cfsd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              data_valid,
    output logic              data_ready,
    input  logic [7:0]        data_byte,
    input  logic              queue_full,
    output logic              push,
    output cfsd_pkg::token_t  push_tok
);
    import cfsd_pkg::*;

    typedef enum logic [3:0] {
        PH_COUNT  = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_STRING = 4'b0100,
        PH_INT    = 4'b1000
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [7:0]           structs_left_reg, structs_left_next;
    logic [STR_LEN_W-1:0] bytes_left_reg, bytes_left_next;
    logic                 closes_reg, closes_next;
    logic                 signed_reg, signed_next;
    logic [2:0]           int_len_reg, int_len_next;

    logic                 accept;
    logic                 done;
    logic [INT_LEN_W-1:0] hdr_int_len;
    logic [STR_LEN_W-1:0] hdr_str_len;
    kind_t                int_kind;

    assign data_ready  = !queue_full;
    assign accept      = data_valid && data_ready;
    assign hdr_int_len = data_byte[INT_LEN_W-1:0];
    assign hdr_str_len = data_byte[STR_LEN_W-1:0];

    always_comb
    begin
        phase_t     ph_after;
        logic       cl;
        logic [7:0] sl_after;
        phase_next        = phase_reg;
        structs_left_next = structs_left_reg;
        bytes_left_next   = bytes_left_reg;
        closes_next       = closes_reg;
        signed_next       = signed_reg;
        int_len_next      = int_len_reg;
        push              = 1'b0;
        push_tok          = '{op: OP_EMIT, kind: KIND_COUNT, data: data_byte,
                              field_end: 1'b0, struct_end: 1'b0, stream_end: 1'b0,
                              is_signed: signed_reg, int_len: int_len_reg};
        int_kind          = signed_reg ? KIND_SIGNED : KIND_UNSIGNED;
        done              = 1'b0;

        // field close: uses closes flag of the current field
        cl       = (phase_reg == PH_HEADER) ? data_byte[HDR_LAST_BIT] : closes_reg;
        sl_after = cl ? structs_left_reg - 8'd1 : structs_left_reg;
        done     = cl && (structs_left_reg == 8'd1);
        ph_after = done ? PH_COUNT : PH_HEADER;

        if (accept)
        begin
            case (phase_reg)
                PH_COUNT:
                begin
                    structs_left_next = data_byte;
                    phase_next        = (data_byte == 8'd0) ? PH_COUNT : PH_HEADER;
                    push              = 1'b1;
                    push_tok.stream_end = (data_byte == 8'd0);
                end
                PH_HEADER:
                begin
                    closes_next = cl;
                    if (data_byte[HDR_STRING_BIT])
                    begin
                        bytes_left_next = hdr_str_len;
                        if (hdr_str_len == '0)
                        begin
                            structs_left_next   = sl_after;
                            phase_next          = ph_after;
                            push                = 1'b1;
                            push_tok.kind       = KIND_EMPTY;
                            push_tok.data       = 8'd0;
                            push_tok.field_end  = 1'b1;
                            push_tok.struct_end = cl;
                            push_tok.stream_end = done;
                        end
                        else
                        begin
                            phase_next = PH_STRING;
                        end
                    end
                    else
                    begin
                        signed_next = data_byte[HDR_SIGNED_BIT];
                        int_kind    = data_byte[HDR_SIGNED_BIT] ? KIND_SIGNED
                                                                 : KIND_UNSIGNED;
                        if (hdr_int_len > INT_LEN_W'(INT_LEN_MAX))
                        begin
                            structs_left_next  = 8'd0;
                            bytes_left_next    = '0;
                            phase_next         = PH_COUNT;
                            push               = 1'b1;
                            push_tok.kind      = KIND_ERROR;
                            push_tok.field_end = 1'b1;
                        end
                        else
                        begin
                            int_len_next    = hdr_int_len[2:0];
                            bytes_left_next = STR_LEN_W'(hdr_int_len);
                            if (hdr_int_len == '0)
                            begin
                                structs_left_next   = sl_after;
                                phase_next          = ph_after;
                                push                = 1'b1;
                                push_tok.kind       = int_kind;
                                push_tok.data       = 8'd0;
                                push_tok.field_end  = 1'b1;
                                push_tok.struct_end = cl;
                                push_tok.stream_end = done;
                            end
                            else
                            begin
                                phase_next = PH_INT;
                            end
                        end
                    end
                end
                PH_STRING:
                begin
                    bytes_left_next = bytes_left_reg - STR_LEN_W'(1);
                    push            = 1'b1;
                    push_tok.kind   = KIND_CHAR;
                    if (bytes_left_reg == STR_LEN_W'(1))
                    begin
                        structs_left_next   = sl_after;
                        phase_next          = ph_after;
                        push_tok.field_end  = 1'b1;
                        push_tok.struct_end = cl;
                        push_tok.stream_end = done;
                    end
                end
                PH_INT:
                begin
                    bytes_left_next = bytes_left_reg - STR_LEN_W'(1);
                    push            = 1'b1;
                    push_tok.kind   = int_kind;
                    if (bytes_left_reg == STR_LEN_W'(1))
                    begin
                        structs_left_next   = sl_after;
                        phase_next          = ph_after;
                        push_tok.op         = OP_LAST;
                        push_tok.field_end  = 1'b1;
                        push_tok.struct_end = cl;
                        push_tok.stream_end = done;
                    end
                    else
                    begin
                        push_tok.op = OP_ACC;
                    end
                end
                default:
                begin
                    phase_next = PH_COUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_COUNT;
            structs_left_reg <= '0;
            bytes_left_reg   <= '0;
            closes_reg       <= 1'b0;
            signed_reg       <= 1'b0;
            int_len_reg      <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            structs_left_reg <= structs_left_next;
            bytes_left_reg   <= bytes_left_next;
            closes_reg       <= closes_next;
            signed_reg       <= signed_next;
            int_len_reg      <= int_len_next;
        end
    end

`ifndef SYNTHESIS
    a_int_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_INT |-> bytes_left_reg != '0
                                && bytes_left_reg <= STR_LEN_W'(INT_LEN_MAX))
        else $error("integer payload count out of range");

    a_count_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_COUNT |-> push && push_tok.kind == KIND_COUNT)
        else $error("count byte did not produce a count token");
`endif

endmodule

// ===== hw/rtl/cfsd_queue.sv =====
// ----------------------------------------------------------------------------
// cfsd_queue
// Small token FIFO between parser and result stage.
// ----------------------------------------------------------------------------
module cfsd_queue #(
    parameter int unsigned DEPTH = cfsd_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cfsd_pkg::token_t  push_tok,
    output logic              full,
    input  logic              pop,
    output cfsd_pkg::token_t  pop_tok,
    output logic              not_empty
);
    import cfsd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    token_t           slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_tok   = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                             : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                             : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_tok;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue pop while empty");
`endif

endmodule

// ===== hw/rtl/cfsd_back.sv =====
// ----------------------------------------------------------------------------
// cfsd_back
// Result stage: accumulates integer payload, sign-extends, and holds the
// output register.
// ----------------------------------------------------------------------------
module cfsd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    input  cfsd_pkg::token_t  tok,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [2:0]        record_kind,
    output logic [31:0]       value,
    output logic              field_end,
    output logic              struct_end,
    output logic              stream_end
);
    import cfsd_pkg::*;

    logic [23:0] acc_reg, acc_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  kind_reg;
    logic [31:0] value_reg;
    logic        field_end_reg, struct_end_reg, stream_end_reg;

    logic        out_free;
    logic        load;
    logic [31:0] full_word;
    logic [31:0] int_value;
    logic [31:0] load_value;

    assign out_free  = !out_valid_reg || result_ready;
    assign pop       = tok_valid && (tok.op == OP_ACC || out_free);
    assign load      = pop && tok.op != OP_ACC;
    assign full_word = {acc_reg, tok.data};

    always_comb
    begin
        int_value = full_word;
        if (tok.is_signed)
        begin
            case (tok.int_len)
                3'd1:    int_value = {{24{full_word[7]}}, full_word[7:0]};
                3'd2:    int_value = {{16{full_word[15]}}, full_word[15:0]};
                3'd3:    int_value = {{8{full_word[23]}}, full_word[23:0]};
                default: int_value = full_word;
            endcase
        end
        load_value = (tok.op == OP_LAST) ? int_value : {24'd0, tok.data};
    end

    always_comb
    begin
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        if (pop && tok.op == OP_ACC)
        begin
            acc_next = full_word[23:0];
        end
        else if (pop && tok.op == OP_LAST)
        begin
            acc_next = '0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg       <= tok.kind;
            value_reg      <= load_value;
            field_end_reg  <= tok.field_end;
            struct_end_reg <= tok.struct_end;
            stream_end_reg <= tok.stream_end;
        end
    end

    assign result_valid = out_valid_reg;
    assign record_kind  = kind_reg;
    assign value        = value_reg;
    assign field_end    = field_end_reg;
    assign struct_end   = struct_end_reg;
    assign stream_end   = stream_end_reg;

`ifndef SYNTHESIS
    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        pop && tok.op == OP_LAST |=> acc_reg == '0)
        else $error("accumulator not cleared after integer");
`endif

endmodule

// ===== hw/rtl/compact_field_stream_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// compact_field_stream_decoder_unit
// Compacted record stream decoder, one byte per transfer.
// ----------------------------------------------------------------------------
// Takes one byte per cycle at full rate while the token queue has room. A
// parser tracks count, header and payload phases and posts a token for each
// byte that yields a result or feeds an integer; a result stage accumulates
// big-endian integers, sign-extends them and holds the output register. A
// QUEUE_DEPTH-entry token queue decouples the two, so a byte is taken whenever
// the queue has room. A result token is first written into a queue slot and
// then loaded into the output register before the result is presented.
module compact_field_stream_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = cfsd_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  record_kind,
    output logic [31:0] value,
    output logic        field_end,
    output logic        struct_end,
    output logic        stream_end
);
    import cfsd_pkg::*;

    logic   push;
    token_t push_tok;
    logic   queue_full;
    logic   pop;
    token_t pop_tok;
    logic   tok_valid;

    cfsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .data_byte  (data_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_tok   (push_tok)
    );

    cfsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_tok  (push_tok),
        .full      (queue_full),
        .pop       (pop),
        .pop_tok   (pop_tok),
        .not_empty (tok_valid)
    );

    cfsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (tok_valid),
        .tok          (pop_tok),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .record_kind  (record_kind),
        .value        (value),
        .field_end    (field_end),
        .struct_end   (struct_end),
        .stream_end   (stream_end)
    );

endmodule

// ===== bench/tb_compact_field_stream_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_compact_field_stream_decoder_unit
// Self-checking bench for the compact field stream decoder. A directed byte
// sequence covers zero counts, empty strings, zero-length and sign-extended
// integers, format errors and resync. It is followed by random record sets
// with noise bytes and error headers mixed in. A scoreboard class predicts
// every result from the accepted bytes and checks each output transfer in
// order. Both sides idle at random, and once the receiver holds off long
// enough to back up the block's input.
// ----------------------------------------------------------------------------
module tb_compact_field_stream_decoder_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import cfsd_pkg::*;

    localparam int unsigned RANDOM_BYTES  = 400;
    localparam int unsigned HOLD_AT       = 120;
    localparam int unsigned HOLD_CYCLES   = 150;
    localparam int unsigned DRAIN_CYCLES  = 16;

    typedef enum logic [1:0] {
        PH_COUNT  = 2'd0,
        PH_HEADER = 2'd1,
        PH_STRING = 2'd2,
        PH_INT    = 2'd3
    } parse_phase_t;

    typedef enum logic [1:0] {
        FT_STRING   = 2'd0,
        FT_SIGNED   = 2'd1,
        FT_UNSIGNED = 2'd2
    } field_type_t;

    typedef struct {
        kind_t       kind;
        logic [31:0] value;
        logic        field_end;
        logic        struct_end;
        logic        stream_end;
    } decoded_t;

    class record_scoreboard;
        parse_phase_t phase;
        logic [7:0]   structs_left;
        logic [5:0]   bytes_left;
        field_type_t  ftype;
        logic [31:0]  acc;
        logic [2:0]   int_len;
        logic         closes;
        decoded_t     pending[$];
        int unsigned  err_count;

        function new();
            phase        = PH_COUNT;
            structs_left = '0;
            bytes_left   = '0;
            ftype        = FT_STRING;
            acc          = '0;
            int_len      = '0;
            closes       = 1'b0;
            err_count    = 0;
        endfunction

        function logic close_field();
            logic done;
            done = 1'b0;
            if (closes)
            begin
                structs_left = structs_left - 8'd1;
                done = (structs_left == 8'd0);
            end
            phase = done ? PH_COUNT : PH_HEADER;
            return done;
        endfunction

        function void push(kind_t k, logic [31:0] v, logic fe, logic se, logic st);
            decoded_t d;
            d.kind       = k;
            d.value      = v;
            d.field_end  = fe;
            d.struct_end = se;
            d.stream_end = st;
            pending.push_back(d);
        endfunction

        function kind_t int_kind();
            return (ftype == FT_SIGNED) ? KIND_SIGNED : KIND_UNSIGNED;
        endfunction

        function void note_byte(logic [7:0] b);
            logic        done;
            logic [4:0]  len;
            logic [31:0] v;
            case (phase)
                PH_COUNT:
                begin
                    structs_left = b;
                    phase = (b == 8'd0) ? PH_COUNT : PH_HEADER;
                    push(KIND_COUNT, {24'd0, b}, 1'b0, 1'b0, b == 8'd0);
                end
                PH_HEADER:
                begin
                    closes = b[HDR_LAST_BIT];
                    if (b[HDR_STRING_BIT])
                    begin
                        ftype = FT_STRING;
                        bytes_left = b[STR_LEN_W-1:0];
                        if (bytes_left == 6'd0)
                        begin
                            done = close_field();
                            push(KIND_EMPTY, 32'd0, 1'b1, closes, done);
                        end
                        else
                        begin
                            phase = PH_STRING;
                        end
                    end
                    else
                    begin
                        ftype = b[HDR_SIGNED_BIT] ? FT_SIGNED : FT_UNSIGNED;
                        len = b[INT_LEN_W-1:0];
                        if (len > INT_LEN_MAX)
                        begin
                            structs_left = '0;
                            bytes_left   = '0;
                            phase        = PH_COUNT;
                            push(KIND_ERROR, {24'd0, b}, 1'b1, 1'b0, 1'b0);
                        end
                        else
                        begin
                            acc        = '0;
                            int_len    = len[2:0];
                            bytes_left = {1'b0, len};
                            if (len == 5'd0)
                            begin
                                done = close_field();
                                push(int_kind(), 32'd0, 1'b1, closes, done);
                            end
                            else
                            begin
                                phase = PH_INT;
                            end
                        end
                    end
                end
                PH_STRING:
                begin
                    bytes_left = bytes_left - 6'd1;
                    if (bytes_left == 6'd0)
                    begin
                        done = close_field();
                        push(KIND_CHAR, {24'd0, b}, 1'b1, closes, done);
                    end
                    else
                    begin
                        push(KIND_CHAR, {24'd0, b}, 1'b0, 1'b0, 1'b0);
                    end
                end
                default:
                begin
                    acc = {acc[23:0], b};
                    bytes_left = bytes_left - 6'd1;
                    if (bytes_left == 6'd0)
                    begin
                        v = acc;
                        if (ftype == FT_SIGNED)
                        begin
                            case (int_len)
                                3'd1: v = {{24{acc[7]}}, acc[7:0]};
                                3'd2: v = {{16{acc[15]}}, acc[15:0]};
                                3'd3: v = {{8{acc[23]}}, acc[23:0]};
                                default: v = acc;
                            endcase
                        end
                        done = close_field();
                        push(int_kind(), v, 1'b1, closes, done);
                    end
                end
            endcase
        endfunction

        function void check_result(logic [2:0] kind, logic [31:0] v, logic fe,
                                   logic se, logic st);
            decoded_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result: record_kind %0d value %h", kind, v);
                err_count++;
                return;
            end
            e = pending.pop_front();
            if (kind !== e.kind)
            begin
                $error("record_kind: expected %0d, got %0d", e.kind, kind);
                err_count++;
            end
            if (v !== e.value)
            begin
                $error("value: expected %h, got %h", e.value, v);
                err_count++;
            end
            if (fe !== e.field_end)
            begin
                $error("field_end: expected %0b, got %0b", e.field_end, fe);
                err_count++;
            end
            if (se !== e.struct_end)
            begin
                $error("struct_end: expected %0b, got %0b", e.struct_end, se);
                err_count++;
            end
            if (st !== e.stream_end)
            begin
                $error("stream_end: expected %0b, got %0b", e.stream_end, st);
                err_count++;
            end
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        data_valid   = 1'b0;
    logic [7:0]  data_byte    = 8'd0;
    logic        result_ready = 1'b0;
    logic        data_ready;
    logic        result_valid;
    logic [2:0]  record_kind;
    logic [31:0] value;
    logic        field_end;
    logic        struct_end;
    logic        stream_end;

    record_scoreboard sb;
    logic [7:0]       stream_q[$];

    logic [7:0] directed_bytes [24] = '{
        8'h00,                                  // zero count
        8'h03,
        8'h42, 8'h00, 8'hFF,                    // two-char string
        8'hA0,                                  // zero-length signed, last
        8'h80,                                  // zero-length unsigned, last
        8'h21, 8'h80,                           // signed byte, negative
        8'hA3, 8'hFF, 8'h00, 8'h01,             // signed 3 bytes, last
        8'h02,
        8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF,      // unsigned 4 bytes, last
        8'h25,                                  // length 5: error, resync
        8'h01,
        8'h3F,                                  // length 31: error
        8'h01,
        8'hC0                                   // empty string, last
    };

    always #2 clk = ~clk;

    compact_field_stream_decoder_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .record_kind  (record_kind),
        .value        (value),
        .field_end    (field_end),
        .struct_end   (struct_end),
        .stream_end   (stream_end)
    );

    // Returns 1 when the field broke the record set.
    function automatic bit add_field(logic last);
        int unsigned r;
        int unsigned len;
        logic        sgn;
        r = $urandom_range(0, 19);
        sgn = 1'($urandom_range(0, 1));
        if (r == 0)
        begin
            stream_q.push_back(8'($urandom_range(0, 255)));
            return 1'b0;
        end
        if (r == 1)
        begin
            len = $urandom_range(INT_LEN_MAX + 1, 31);
            stream_q.push_back({last, 1'b0, sgn, 5'(len)});
            return 1'b1;
        end
        if (r < 9)
        begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(32, 63) : $urandom_range(0, 6);
            stream_q.push_back({last, 1'b1, 6'(len)});
        end
        else
        begin
            len = $urandom_range(0, INT_LEN_MAX);
            stream_q.push_back({last, 1'b0, sgn, 5'(len)});
        end
        repeat (len) stream_q.push_back(8'($urandom_range(0, 255)));
        return 1'b0;
    endfunction

    function automatic void add_record_set();
        int unsigned r;
        int unsigned cnt;
        int unsigned nf;
        r = $urandom_range(0, 9);
        cnt = (r == 0) ? 0 : (r < 8) ? $urandom_range(1, 3) : $urandom_range(4, 6);
        stream_q.push_back(8'(cnt));
        for (int s = 0; s < cnt; s++)
        begin
            nf = $urandom_range(1, 3);
            for (int f = 0; f < nf; f++)
            begin
                if (add_field(f == nf - 1))
                    return;
            end
        end
    endfunction

    task automatic send_stream();
        int unsigned gap;
        for (int i = 0; i < stream_q.size(); i++)
        begin
            gap = ((i % 80) < 20) ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                data_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            data_valid <= 1'b1;
            data_byte  <= stream_q[i];
            @(posedge clk);
            while (!data_ready) @(posedge clk);
            sb.note_byte(stream_q[i]);
        end
        data_valid <= 1'b0;
    endtask

    task automatic receive_results();
        int unsigned n;
        int unsigned stall;
        n = 0;
        forever
        begin
            if (n == HOLD_AT)
                stall = HOLD_CYCLES;
            else if ((n % 70) < 15)
                stall = 0;
            else
                stall = $urandom_range(0, 5);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
            sb.check_result(record_kind, value, field_end, struct_end, stream_end);
            n++;
        end
    endtask

    initial
    begin
        #200000;
        $display("tb_compact_field_stream_decoder_unit failed");
        $finish;
    end

    initial
    begin
        int unsigned base;
        sb = new();
        foreach (directed_bytes[i]) stream_q.push_back(directed_bytes[i]);
        base = stream_q.size();
        while (stream_q.size() < base + RANDOM_BYTES) add_record_set();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            receive_results();
        join_none
        send_stream();

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending.size());
            sb.err_count++;
        end
        if (sb.err_count == 0)
            $display("tb_compact_field_stream_decoder_unit passed");
        else
            $display("tb_compact_field_stream_decoder_unit failed");
        $finish;
    end

endmodule

// ===== compact_field_stream_decoder_unit.f =====
hw/rtl/cfsd_pkg.sv
hw/rtl/cfsd_front.sv
hw/rtl/cfsd_queue.sv
hw/rtl/cfsd_back.sv
hw/rtl/compact_field_stream_decoder_unit.sv
bench/tb_compact_field_stream_decoder_unit.sv
